FILE: design/lfss_pkg.sv
// Shared constants, command codes and control types of the frequency sweep sequencer.
package lfss_pkg;

   localparam int MAX_POINTS_DEF = 256;

   localparam int FREQ_W    = 26;
   localparam int SETTLE_W  = 16;
   localparam int NSAMP_W   = 7;
   localparam int CODE_W    = 12;
   localparam int IDX_W     = 8;
   localparam int ELAPSED_W = 17;
   localparam int SUM_W     = 18;
   localparam int CMD_W     = 3;
   localparam int CSR_IDX_W = 3;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 2;

   localparam int TICK_MS     = 10;
   localparam int NSAMP_RESET = 16;
   localparam int NSAMP_MAX   = 64;

   localparam int DIV_BITS  = 3;
   localparam int DIV_ITERS = SUM_W / DIV_BITS;

   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_START_FREQ  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_FREQ   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_HZ     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SETTLE_MS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_SAMPLES = 3'd4;

   typedef struct packed {
      logic load_in;
      logic exec;
      logic issue_freq;
      logic settle_tick;
      logic enter_sample;
      logic add_sample;
      logic finish_point;
      logic next_point;
      logic start_sweep;
      logic div_step;
      logic push;
      logic running;
      logic complete;
   } lfss_ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             settle_done;
      logic             count_done;
      logic             last_point;
      logic             empty_sweep;
      logic             div_done;
   } lfss_sts_type;

endpackage

FILE: design/lfss_dp.sv
// Datapath of the sweep sequencer: settings, sweep counters, sample divider and result register.
module lfss_dp #(
   parameter int MAX_POINTS = lfss_pkg::MAX_POINTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lfss_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [lfss_pkg::CMD_W-1:0]          req_tuser,
   input  logic                                csr_valid,
   input  logic [lfss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lfss_pkg::FREQ_W-1:0]         csr_data,
   input  lfss_pkg::lfss_ctl_type              ctl,
   output lfss_pkg::lfss_sts_type              sts,
   output logic [lfss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [lfss_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import lfss_pkg::*;

   localparam int PTS_W = IDX_W + 1;
   localparam logic [PTS_W-1:0] MAX_PTS = PTS_W'(MAX_POINTS);

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [CODE_W-1:0]    code_ff, code_in;

   logic [FREQ_W-1:0]    start_ff, start_in;
   logic [FREQ_W-1:0]    stop_ff, stop_in;
   logic [FREQ_W-1:0]    step_ff, step_in;
   logic [SETTLE_W-1:0]  settle_ff, settle_in;
   logic [NSAMP_W-1:0]   nsamp_ff, nsamp_in;

   logic [FREQ_W-1:0]    lat_stop_ff, lat_stop_in;
   logic [FREQ_W-1:0]    lat_step_ff, lat_step_in;
   logic [SETTLE_W-1:0]  lat_settle_ff, lat_settle_in;
   logic [NSAMP_W-1:0]   lat_n_ff, lat_n_in;
   logic [FREQ_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [NSAMP_W-1:0]   scount_ff, scount_in;

   logic                 sfv_ff, sfv_in;
   logic [FREQ_W-1:0]    dds_ff, dds_in;
   logic                 pv_ff, pv_in;
   logic [IDX_W-1:0]     pidx_ff, pidx_in;
   logic [FREQ_W-1:0]    pf_ff, pf_in;

   logic [NSAMP_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [2:0]           div_cnt_ff, div_cnt_in;

   logic [RSP_DATA_W-1:0] tdata_ff, tdata_in;
   logic [RSP_USER_W-1:0] tuser_ff, tuser_in;

   logic [ELAPSED_W:0]   elapsed_sum;
   logic [ELAPSED_W-1:0] elapsed_sat;
   logic [NSAMP_W-1:0]   scount_next;
   logic [FREQ_W:0]      freq_next;
   logic [SUM_W-1:0]     sum_next;
   logic [NSAMP_W-1:0]   nsamp_clamp;
   logic [NSAMP_W-1:0]   div_rem;
   logic [SUM_W-1:0]     div_quo;
   logic [CODE_W-1:0]    mean;

   assign elapsed_sum = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(TICK_MS);
   assign elapsed_sat = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
   assign scount_next = scount_ff + NSAMP_W'(1);
   assign freq_next   = {1'b0, cur_ff} + {1'b0, lat_step_ff};
   assign sum_next    = sum_ff + SUM_W'(code_ff);

   always_comb begin
      priority if (nsamp_ff == '0) begin
         nsamp_clamp = NSAMP_W'(1);
      end else if (nsamp_ff > NSAMP_W'(NSAMP_MAX)) begin
         nsamp_clamp = NSAMP_W'(NSAMP_MAX);
      end else begin
         nsamp_clamp = nsamp_ff;
      end
   end

   // Restoring division, a few quotient bits per cycle.
   always_comb begin
      logic [NSAMP_W:0] r;
      logic [NSAMP_W-1:0] rm;
      logic [SUM_W-1:0] q;
      logic qb;
      rm = rem_ff;
      q  = quo_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         r  = {rm, q[SUM_W-1]};
         qb = 1'b0;
         if (r >= {1'b0, lat_n_ff}) begin
            r  = r - {1'b0, lat_n_ff};
            qb = 1'b1;
         end
         q  = {q[SUM_W-2:0], qb};
         rm = r[NSAMP_W-1:0];
      end
      div_rem = rm;
      div_quo = q;
   end

   always_comb begin
      sts.cmd         = cmd_ff;
      sts.settle_done = elapsed_sat >= ELAPSED_W'(lat_settle_ff);
      sts.count_done  = scount_next >= lat_n_ff;
      sts.last_point  = (({1'b0, cnt_ff} + PTS_W'(1)) >= MAX_PTS) ||
                        (freq_next > {1'b0, lat_stop_ff});
      sts.empty_sweep = (step_ff == '0) || (start_ff > stop_ff);
      sts.div_done    = div_cnt_ff == 3'(DIV_ITERS - 1);
   end

   always_comb begin
      cmd_in  = cmd_ff;
      code_in = code_ff;
      if (ctl.load_in) begin
         cmd_in  = req_tuser;
         code_in = req_tdata[CODE_W-1:0];
      end

      start_in  = start_ff;
      stop_in   = stop_ff;
      step_in   = step_ff;
      settle_in = settle_ff;
      nsamp_in  = nsamp_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_START_FREQ:  start_in  = csr_data;
            REG_STOP_FREQ:   stop_in   = csr_data;
            REG_STEP_HZ:     step_in   = csr_data;
            REG_SETTLE_MS:   settle_in = csr_data[SETTLE_W-1:0];
            REG_NUM_SAMPLES: nsamp_in  = csr_data[NSAMP_W-1:0];
            default: ;
         endcase
      end

      lat_stop_in   = lat_stop_ff;
      lat_step_in   = lat_step_ff;
      lat_settle_in = lat_settle_ff;
      lat_n_in      = lat_n_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      elapsed_in    = elapsed_ff;
      sum_in        = sum_ff;
      scount_in     = scount_ff;

      if (ctl.start_sweep) begin
         lat_stop_in   = stop_ff;
         lat_step_in   = step_ff;
         lat_settle_in = settle_ff;
         lat_n_in      = nsamp_clamp;
         cur_in        = start_ff;
         cnt_in        = '0;
         elapsed_in    = '0;
         sum_in        = '0;
         scount_in     = '0;
      end
      if (ctl.issue_freq) begin
         elapsed_in = '0;
      end
      if (ctl.settle_tick) begin
         elapsed_in = elapsed_sat;
      end
      if (ctl.enter_sample) begin
         sum_in    = '0;
         scount_in = '0;
      end
      if (ctl.add_sample) begin
         sum_in    = sum_next;
         scount_in = scount_next;
      end
      if (ctl.next_point) begin
         cnt_in = cnt_ff + IDX_W'(1);
         cur_in = freq_next[FREQ_W-1:0];
      end

      sfv_in  = sfv_ff;
      dds_in  = dds_ff;
      pv_in   = pv_ff;
      pidx_in = pidx_ff;
      pf_in   = pf_ff;
      if (ctl.exec) begin
         sfv_in  = ctl.issue_freq;
         dds_in  = ctl.issue_freq ? cur_ff : '0;
         pv_in   = ctl.finish_point;
         pidx_in = ctl.finish_point ? cnt_ff : '0;
         pf_in   = ctl.finish_point ? cur_ff : '0;
      end

      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (ctl.finish_point) begin
         rem_in     = '0;
         quo_in     = sum_next;
         div_cnt_in = '0;
      end else if (ctl.div_step) begin
         rem_in     = div_rem;
         quo_in     = div_quo;
         div_cnt_in = div_cnt_ff + 3'd1;
      end

      mean     = pv_ff ? quo_ff[CODE_W-1:0] : '0;
      tdata_in = tdata_ff;
      tuser_in = tuser_ff;
      if (ctl.push) begin
         tdata_in = {6'd0, ctl.complete, ctl.running, mean, pf_ff, pidx_ff, dds_ff};
         tuser_in = {pv_ff, sfv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff      <= '0;
         stop_ff       <= '0;
         step_ff       <= '0;
         settle_ff     <= '0;
         nsamp_ff      <= NSAMP_W'(NSAMP_RESET);
         lat_stop_ff   <= '0;
         lat_step_ff   <= '0;
         lat_settle_ff <= '0;
         lat_n_ff      <= NSAMP_W'(NSAMP_RESET);
         cur_ff        <= '0;
         cnt_ff        <= '0;
         elapsed_ff    <= '0;
         sum_ff        <= '0;
         scount_ff     <= '0;
         div_cnt_ff    <= '0;
      end else begin
         start_ff      <= start_in;
         stop_ff       <= stop_in;
         step_ff       <= step_in;
         settle_ff     <= settle_in;
         nsamp_ff      <= nsamp_in;
         lat_stop_ff   <= lat_stop_in;
         lat_step_ff   <= lat_step_in;
         lat_settle_ff <= lat_settle_in;
         lat_n_ff      <= lat_n_in;
         cur_ff        <= cur_in;
         cnt_ff        <= cnt_in;
         elapsed_ff    <= elapsed_in;
         sum_ff        <= sum_in;
         scount_ff     <= scount_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      code_ff  <= code_in;
      sfv_ff   <= sfv_in;
      dds_ff   <= dds_in;
      pv_ff    <= pv_in;
      pidx_ff  <= pidx_in;
      pf_ff    <= pf_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      tdata_ff <= tdata_in;
      tuser_ff <= tuser_in;
   end

   assign rsp_tdata = tdata_ff;
   assign rsp_tuser = tuser_ff;

endmodule

FILE: design/lfss_ctrl.sv
// Controller of the sweep sequencer: request flow, sweep phase and status flags.
module lfss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  lfss_pkg::lfss_sts_type sts,
   output lfss_pkg::lfss_ctl_type ctl
);
   import lfss_pkg::*;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_EXEC = 2'd1;
   localparam logic [1:0] F_DIV  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   localparam logic [1:0] P_IDLE   = 2'd0;
   localparam logic [1:0] P_SETF   = 2'd1;
   localparam logic [1:0] P_SETTLE = 2'd2;
   localparam logic [1:0] P_SAMPLE = 2'd3;

   logic [1:0] flow_ff, flow_in;
   logic [1:0] phase_ff, phase_in;
   logic       complete_ff, complete_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = flow_ff == F_IDLE;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      flow_in      = flow_ff;
      phase_in     = phase_ff;
      complete_in  = complete_ff;
      ctl          = '0;
      ctl.running  = phase_ff != P_IDLE;
      ctl.complete = complete_ff;

      unique case (flow_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               ctl.load_in = 1'b1;
               flow_in     = F_EXEC;
            end
         end
         F_EXEC: begin
            ctl.exec = 1'b1;
            flow_in  = F_PUSH;
            unique case (sts.cmd)
               CMD_TICK: begin
                  if (phase_ff == P_SETF) begin
                     ctl.issue_freq = 1'b1;
                     phase_in       = P_SETTLE;
                  end else if (phase_ff == P_SETTLE) begin
                     ctl.settle_tick = 1'b1;
                     if (sts.settle_done) begin
                        ctl.enter_sample = 1'b1;
                        phase_in         = P_SAMPLE;
                     end
                  end
               end
               CMD_SAMPLE: begin
                  if (phase_ff == P_SAMPLE) begin
                     ctl.add_sample = 1'b1;
                     if (sts.count_done) begin
                        ctl.finish_point = 1'b1;
                        flow_in          = F_DIV;
                        if (sts.last_point) begin
                           phase_in    = P_IDLE;
                           complete_in = 1'b1;
                        end else begin
                           ctl.next_point = 1'b1;
                           phase_in       = P_SETF;
                        end
                     end
                  end
               end
               CMD_START: begin
                  if (phase_ff == P_IDLE) begin
                     ctl.start_sweep = 1'b1;
                     if (sts.empty_sweep) begin
                        complete_in = 1'b1;
                     end else begin
                        complete_in = 1'b0;
                        phase_in    = P_SETF;
                     end
                  end
               end
               CMD_STOP: begin
                  phase_in = P_IDLE;
               end
               CMD_CLEAR: begin
                  complete_in = 1'b0;
               end
               default: ;
            endcase
         end
         F_DIV: begin
            ctl.div_step = 1'b1;
            if (sts.div_done) begin
               flow_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (out_free) begin
               ctl.push = 1'b1;
               flow_in  = F_IDLE;
            end
         end
         default: ;
      endcase

      rsp_valid_in = ctl.push || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_ff      <= F_IDLE;
         phase_ff     <= P_IDLE;
         complete_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flow_ff      <= flow_in;
         phase_ff     <= phase_in;
         complete_ff  <= complete_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_run_excl: assert property (@(posedge clock) disable iff (reset)
      !(phase_ff != P_IDLE && complete_ff))
      else $error("running and complete are both set");

   a_point_div: assert property (@(posedge clock) disable iff (reset)
      ctl.finish_point |=> flow_ff == F_DIV)
      else $error("finished point did not start the divider");

   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.push |=> req_tready && rsp_tvalid)
      else $error("push did not present a result and reopen the input");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(flow_ff) == F_PUSH)
      else $error("result appeared outside the push step");

endmodule

FILE: design/linear_frequency_sweep_sequencer_core.sv
// Top level of the linear frequency sweep sequencer.
// The req_ channel carries one command per request: tuser holds the command
// (tick, ADC sample, start, stop, clear complete) and tdata the ADC code.
// Every request yields exactly one response on the rsp_ channel with the DDS
// frequency command, any finished point (index, frequency, mean code) and the
// running and complete flags after that request.
// The csr_ channel writes the sweep settings, which a start command latches;
// write them only while no request is in flight.
// A request passes an execute step and a push step that loads the response register;
// a new request is accepted only once the previous one has been pushed. A sample
// that finishes a point adds divider steps between them, in which the divider forms
// the mean three quotient bits a cycle.
// Reset clears the sweep, the flags and the settings, with the sample count at 16.
// A stalled response sits in the output register while the next request is
// already processed; that request then waits until the register is taken.
module linear_frequency_sweep_sequencer_core #(
   parameter int MAX_POINTS = lfss_pkg::MAX_POINTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [lfss_pkg::REQ_DATA_W-1:0] req_tdata,  // adc_code, zero fill
   input  logic [lfss_pkg::CMD_W-1:0]      req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // dds_freq, point_index, point_freq, point_mean, running, complete, zero fill
   output logic [lfss_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [lfss_pkg::RSP_USER_W-1:0] rsp_tuser,  // set_freq_valid, point_valid
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lfss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfss_pkg::FREQ_W-1:0]     csr_data
);
   import lfss_pkg::*;

   lfss_ctl_type ctl;
   lfss_sts_type sts;

   assign csr_ready = 1'b1;

   lfss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   lfss_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

FILE: verif/tb.sv
// Self-checking testbench of the linear frequency sweep sequencer core.
module tb;
   import lfss_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int FREQ_HIGH    = 40000000;
   localparam int DRAIN_CYCLES = 12;
   localparam int SCRIPT_LEN   = 36;
   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;

   typedef enum logic [1:0] {SW_IDLE, SW_SETF, SW_SETTLE, SW_SAMPLE} sweep_phase_t;
   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_t;

   typedef struct packed {
      logic              set_valid;
      logic [FREQ_W-1:0] dds_freq;
      logic              pt_valid;
      logic [IDX_W-1:0]  pt_index;
      logic [FREQ_W-1:0] pt_freq;
      logic [CODE_W-1:0] pt_mean;
      logic              running;
      logic              complete;
   } sweep_result_t;

   typedef struct packed {
      row_kind_t         kind;
      logic [2:0]        sel;
      logic [FREQ_W-1:0] value;
      logic              fixed;
      sweep_result_t     want;
   } script_row_t;

   localparam sweep_result_t IDLE_RESP = '0;
   localparam sweep_result_t RUN_RESP =
      '{1'b0, 26'd0, 1'b0, 8'd0, 26'd0, 12'd0, 1'b1, 1'b0};
   localparam sweep_result_t DONE_RESP =
      '{1'b0, 26'd0, 1'b0, 8'd0, 26'd0, 12'd0, 1'b0, 1'b1};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [FREQ_W-1:0]     csr_data   = '0;

   // Register shadows and the sweep state as the block should hold it.
   logic [FREQ_W-1:0]   cfg_start = '0, cfg_stop = '0, cfg_step = '0;
   logic [SETTLE_W-1:0] cfg_settle = '0;
   logic [NSAMP_W-1:0]  cfg_nsamp = NSAMP_W'(NSAMP_RESET);
   logic [FREQ_W-1:0]   lat_stop = '0, lat_step = '0;
   logic [SETTLE_W-1:0] lat_settle = '0;
   logic [NSAMP_W-1:0]  lat_nsamp = NSAMP_W'(NSAMP_RESET);
   sweep_phase_t        sw_phase = SW_IDLE;
   logic [IDX_W-1:0]    sw_points = '0;
   logic [FREQ_W-1:0]   sw_freq = '0;
   logic [ELAPSED_W-1:0] sw_elapsed = '0;
   logic [SUM_W-1:0]    sw_sum = '0;
   logic [NSAMP_W-1:0]  sw_count = '0;
   logic                sw_running = 1'b0, sw_done = 1'b0;

   sweep_result_t expected_responses[$];
   int  mismatches = 0, responses_seen = 0, points_seen = 0;
   int  acting_items = 0, total_items = 0, sweeps = 0, csr_writes = 0;
   int  gap_pct = 15, stall_pct = 15, stall_left = 0, code_mode = 0;
   int  quiet_cycles = 0;
   logic calm = 1'b0;

   script_row_t script [SCRIPT_LEN] = '{
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1, IDLE_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd4095, 1'b1, IDLE_RESP},
      '{ROW_REQ, CMD_START,  26'd0,    1'b1, DONE_RESP},
      '{ROW_REQ, CMD_CLEAR,  26'd0,    1'b1, IDLE_RESP},
      '{ROW_REQ, CMD_SPARE,  26'd4095, 1'b1, IDLE_RESP},
      '{ROW_REQ, CMD_START,  26'd0,    1'b1, DONE_RESP},
      '{ROW_CSR, REG_START_FREQ,  26'd1000, 1'b0, IDLE_RESP},
      '{ROW_CSR, REG_STOP_FREQ,   26'd1020, 1'b0, IDLE_RESP},
      '{ROW_CSR, REG_STEP_HZ,     26'd10,   1'b0, IDLE_RESP},
      '{ROW_CSR, REG_NUM_SAMPLES, 26'd0,    1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_START,  26'd0,    1'b1, RUN_RESP},
      '{ROW_REQ, CMD_START,  26'd0,    1'b1, RUN_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd123,  1'b1, RUN_RESP},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1,
        '{1'b1, 26'd1000, 1'b0, 8'd0, 26'd0, 12'd0, 1'b1, 1'b0}},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1, RUN_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd4095, 1'b1,
        '{1'b0, 26'd0, 1'b1, 8'd0, 26'd1000, 12'd4095, 1'b1, 1'b0}},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1,
        '{1'b1, 26'd1010, 1'b0, 8'd0, 26'd0, 12'd0, 1'b1, 1'b0}},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1, RUN_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd0,    1'b1,
        '{1'b0, 26'd0, 1'b1, 8'd1, 26'd1010, 12'd0, 1'b1, 1'b0}},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1,
        '{1'b1, 26'd1020, 1'b0, 8'd0, 26'd0, 12'd0, 1'b1, 1'b0}},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1, RUN_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd2048, 1'b1,
        '{1'b0, 26'd0, 1'b1, 8'd2, 26'd1020, 12'd2048, 1'b0, 1'b1}},
      '{ROW_REQ, CMD_STOP,   26'd0,    1'b1, DONE_RESP},
      '{ROW_REQ, CMD_CLEAR,  26'd0,    1'b1, IDLE_RESP},
      '{ROW_CSR, REG_SETTLE_MS,   26'd20,  1'b0, IDLE_RESP},
      '{ROW_CSR, REG_NUM_SAMPLES, 26'd127, 1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_START,  26'd0,    1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd77,   1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_SAMPLE, 26'd4095, 1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_STOP,   26'd0,    1'b0, IDLE_RESP},
      '{ROW_CSR, REG_START_FREQ,  26'd40000000, 1'b0, IDLE_RESP},
      '{ROW_REQ, CMD_START,  26'd0,    1'b1, DONE_RESP},
      '{ROW_REQ, CMD_TICK,   26'd0,    1'b1, DONE_RESP}
   };

   linear_frequency_sweep_sequencer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic sweep_result_t predict_sweep_response(input logic [CMD_W-1:0] cmd,
                                                            input logic [CODE_W-1:0] code,
                                                            output logic acted);
      sweep_result_t r;
      logic [ELAPSED_W:0] elapsed_sum;
      logic [FREQ_W:0]    next_freq;
      logic [SUM_W-1:0]   quotient;
      r = '0;
      acted = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (sw_running && sw_phase == SW_SETF) begin
               acted = 1'b1;
               r.set_valid = 1'b1;
               r.dds_freq = sw_freq;
               sw_elapsed = '0;
               sw_phase = SW_SETTLE;
            end else if (sw_running && sw_phase == SW_SETTLE) begin
               acted = 1'b1;
               elapsed_sum = {1'b0, sw_elapsed} + (ELAPSED_W+1)'(TICK_MS);
               sw_elapsed = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
               if (sw_elapsed >= {1'b0, lat_settle}) begin
                  sw_sum = '0;
                  sw_count = '0;
                  sw_phase = SW_SAMPLE;
               end
            end
         end
         CMD_SAMPLE: begin
            if (sw_running && sw_phase == SW_SAMPLE) begin
               acted = 1'b1;
               sw_sum = sw_sum + {{(SUM_W-CODE_W){1'b0}}, code};
               sw_count = sw_count + 1'b1;
               if (sw_count >= lat_nsamp) begin
                  quotient = sw_sum / {{(SUM_W-NSAMP_W){1'b0}}, lat_nsamp};
                  r.pt_valid = 1'b1;
                  r.pt_index = sw_points;
                  r.pt_freq = sw_freq;
                  r.pt_mean = quotient[CODE_W-1:0];
                  next_freq = {1'b0, sw_freq} + {1'b0, lat_step};
                  if (int'(sw_points) + 1 >= MAX_POINTS_DEF || next_freq > {1'b0, lat_stop})
                  begin
                     sw_running = 1'b0;
                     sw_done = 1'b1;
                     sw_phase = SW_IDLE;
                  end else begin
                     sw_points = sw_points + 1'b1;
                     sw_freq = next_freq[FREQ_W-1:0];
                     sw_phase = SW_SETF;
                  end
               end
            end
         end
         CMD_START: begin
            if (!sw_running) begin
               acted = 1'b1;
               sw_done = 1'b0;
               lat_stop = cfg_stop;
               lat_step = cfg_step;
               lat_settle = cfg_settle;
               if (cfg_nsamp == '0) lat_nsamp = NSAMP_W'(1);
               else if (cfg_nsamp > NSAMP_W'(NSAMP_MAX)) lat_nsamp = NSAMP_W'(NSAMP_MAX);
               else lat_nsamp = cfg_nsamp;
               sw_points = '0;
               sw_elapsed = '0;
               sw_sum = '0;
               sw_count = '0;
               sw_freq = cfg_start;
               if (cfg_step == '0 || cfg_start > cfg_stop) begin
                  sw_done = 1'b1;
                  sw_phase = SW_IDLE;
               end else begin
                  sw_running = 1'b1;
                  sw_phase = SW_SETF;
               end
            end
         end
         CMD_STOP: begin
            acted = 1'b1;
            sw_running = 1'b0;
            sw_phase = SW_IDLE;
         end
         CMD_CLEAR: begin
            acted = 1'b1;
            sw_done = 1'b0;
         end
         default: ;
      endcase
      r.running = sw_running;
      r.complete = sw_done;
      return r;
   endfunction

   task automatic flag_mismatch(input string field, input longint unsigned got,
                                input longint unsigned want);
      mismatches++;
      if (mismatches <= 40)
         $display("ERROR response %0d: %s is %0h, should be %0h",
                  responses_seen, field, got, want);
   endtask

   always @(posedge clock) begin : check_responses
      sweep_result_t got;
      sweep_result_t want;
      if (rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[0], rsp_tdata[25:0], rsp_tuser[1], rsp_tdata[33:26],
                 rsp_tdata[59:34], rsp_tdata[71:60], rsp_tdata[72], rsp_tdata[73]};
         if (got.pt_valid) points_seen++;
         if (expected_responses.size() == 0) begin
            flag_mismatch("response without request", 1, 0);
         end else begin
            want = expected_responses.pop_front();
            if (got.set_valid !== want.set_valid)
               flag_mismatch("set_freq_valid", got.set_valid, want.set_valid);
            if (got.dds_freq !== want.dds_freq)
               flag_mismatch("dds_freq", got.dds_freq, want.dds_freq);
            if (got.pt_valid !== want.pt_valid)
               flag_mismatch("point_valid", got.pt_valid, want.pt_valid);
            if (got.pt_index !== want.pt_index)
               flag_mismatch("point_index", got.pt_index, want.pt_index);
            if (got.pt_freq !== want.pt_freq)
               flag_mismatch("point_freq", got.pt_freq, want.pt_freq);
            if (got.pt_mean !== want.pt_mean)
               flag_mismatch("point_mean", got.pt_mean, want.pt_mean);
            if (got.running !== want.running)
               flag_mismatch("running", got.running, want.running);
            if (got.complete !== want.complete)
               flag_mismatch("complete", got.complete, want.complete);
         end
         responses_seen++;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 17);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles.", QUIET_LIMIT);
         $display("linear_frequency_sweep_sequencer_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CODE_W-1:0] pick_code();
      case (code_mode)
         1: return '1;
         2: return '0;
         default: return CODE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                                input logic use_fixed, input sweep_result_t fixed_want);
      sweep_result_t predicted;
      logic acted;
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_W-CODE_W){1'b0}}, code};
      do @(posedge clock); while (!req_tready);
      predicted = predict_sweep_response(cmd, code, acted);
      expected_responses.push_back(use_fixed ? fixed_want : predicted);
      total_items++;
      if (acted) acting_items++;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [FREQ_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_START_FREQ:  cfg_start = data;
         REG_STOP_FREQ:   cfg_stop = data;
         REG_STEP_HZ:     cfg_step = data;
         REG_SETTLE_MS:   cfg_settle = data[SETTLE_W-1:0];
         REG_NUM_SAMPLES: cfg_nsamp = data[NSAMP_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic program_random_setup();
      int unsigned pts, first, stride, last, settle, nsamp;
      case ($urandom_range(0, 15))
         0: nsamp = 0;
         1: nsamp = $urandom_range(65, 127);
         2: nsamp = NSAMP_MAX;
         default: nsamp = $urandom_range(1, 8);
      endcase
      pts = (nsamp > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      stride = $urandom_range(1, 3000000);
      first = $urandom_range(0, FREQ_HIGH / 2);
      last = first + stride * (pts - 1) + $urandom_range(0, stride - 1);
      case ($urandom_range(0, 15))
         0: stride = 0;
         1: begin
            first = $urandom_range(1, FREQ_HIGH);
            last = $urandom_range(0, first - 1);
         end
         2: begin
            first = FREQ_HIGH;
            last = FREQ_HIGH;
            stride = $urandom_range(1, FREQ_HIGH);
         end
         3: begin
            first = 0;
            last = 0;
         end
         4: begin
            first = $urandom_range(0, FREQ_HIGH);
            stride = $urandom_range(1, FREQ_HIGH);
            last = $urandom_range(first, FREQ_HIGH);
         end
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0: settle = 0;
         7: settle = $urandom_range(46, 300);
         default: settle = $urandom_range(1, 45);
      endcase
      program_register(REG_START_FREQ, FREQ_W'(first));
      program_register(REG_STOP_FREQ, FREQ_W'(last));
      program_register(REG_STEP_HZ, FREQ_W'(stride));
      program_register(REG_SETTLE_MS, FREQ_W'(settle));
      program_register(REG_NUM_SAMPLES, FREQ_W'(nsamp));
   endtask

   // Mostly the request the sweep is waiting for, with a share of stray commands.
   task automatic run_sweep(input int noise_pct, input int budget);
      logic [CMD_W-1:0] cmd;
      int n;
      code_mode = $urandom_range(0, 7);
      if (!calm) begin
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 12;
            default: gap_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct <= 0;
            1: stall_pct <= 12;
            default: stall_pct <= 40;
         endcase
      end
      issue_request(CMD_START, pick_code(), 1'b0, IDLE_RESP);
      for (n = 0; sw_running && n < budget; n++) begin
         if ($urandom_range(0, 99) < noise_pct) cmd = CMD_W'($urandom_range(0, 7));
         else if (sw_phase == SW_SAMPLE) cmd = CMD_SAMPLE;
         else cmd = CMD_TICK;
         issue_request(cmd, pick_code(), 1'b0, IDLE_RESP);
      end
      if (sw_running) issue_request(CMD_STOP, pick_code(), 1'b0, IDLE_RESP);
      if ($urandom_range(0, 2) == 0) issue_request(CMD_CLEAR, pick_code(), 1'b0, IDLE_RESP);
      sweeps++;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_drained();
            program_register(script[i].sel, script[i].value);
         end else begin
            issue_request(script[i].sel, script[i].value[CODE_W-1:0], script[i].fixed,
                          script[i].want);
         end
      end

      // A sweep long enough to run into the point limit.
      wait_drained();
      program_register(REG_START_FREQ, FREQ_W'($urandom_range(0, 1000)));
      program_register(REG_STOP_FREQ, FREQ_W'(FREQ_HIGH));
      program_register(REG_STEP_HZ, FREQ_W'($urandom_range(1, 100000)));
      program_register(REG_SETTLE_MS, '0);
      program_register(REG_NUM_SAMPLES, FREQ_W'(1));
      run_sweep(0, 2000);

      // The longest settling time, cut short by a stop.
      wait_drained();
      program_register(REG_SETTLE_MS, FREQ_W'(16'hFFFF));
      program_register(REG_NUM_SAMPLES, FREQ_W'(NSAMP_MAX));
      run_sweep(0, 30);

      while (acting_items < 1500) begin
         wait_drained();
         program_random_setup();
         run_sweep(6, 400);
      end
      calm <= 1'b1;
      gap_pct = 0;
      stall_pct <= 0;
      while (acting_items < 1650) begin
         wait_drained();
         program_random_setup();
         run_sweep(6, 400);
      end

      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d acting) over %0d sweeps with %0d register writes.",
               total_items, acting_items, sweeps, csr_writes);
      $display("Checked %0d responses carrying %0d finished points; %0d errors.",
               responses_seen, points_seen, mismatches);
      if (mismatches == 0) begin
         $display("linear_frequency_sweep_sequencer_core: match");
      end else begin
         $display("linear_frequency_sweep_sequencer_core: mismatch");
      end
      $finish;
   end

endmodule

FILE: linear_frequency_sweep_sequencer_core.f
design/lfss_pkg.sv
design/lfss_dp.sv
design/lfss_ctrl.sv
design/linear_frequency_sweep_sequencer_core.sv
verif/tb.sv
